FILE: rtl/yuyv_to_argb_converter_assert.svh
// ----------------------------------------------------------------------------
// yuyv_to_argb_converter assertion macros
// shared assertion helpers for the converter rtl
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_ARGB_CONVERTER_ASSERT_SVH
`define YUYV_TO_ARGB_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define YTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yta assertion failed");

// next-cycle implication, disabled during reset
`define YTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yta assertion failed");

`endif

FILE: rtl/yta_pkg.sv
// ----------------------------------------------------------------------------
// yta_pkg
// types, constants and helpers for the yuyv to argb converter
// ----------------------------------------------------------------------------
`default_nettype none

package yta_pkg;

  // fixed-point coefficient format
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int DELTA_W = 9;
  localparam int PROD_W = COEF_W + DELTA_W;
  localparam int SUM_W = PROD_W + 2;
  localparam int GAIN_W = 9;
  localparam int SCL_W = 8 + GAIN_W;

  localparam logic signed [COEF_W-1:0] COEF_RV =
    COEF_W'(((64'd1370705 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [COEF_W-1:0] COEF_GV =
    COEF_W'(((64'd698001 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [COEF_W-1:0] COEF_GU =
    COEF_W'(((64'd337633 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [COEF_W-1:0] COEF_BU =
    COEF_W'(((64'd1732446 << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);

  localparam logic [DELTA_W-1:0] CHROMA_OFFSET = DELTA_W'(128);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(220);
  localparam logic [7:0] ALPHA_BYTE = 8'hFF;
  localparam logic [7:0] COMP_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       last_in_frame;
  } yta_in_t;

  typedef struct packed {
    logic [31:0] first_pixel_argb;
    logic [31:0] second_pixel_argb;
    logic        frame_end;
  } yta_out_t;

  // per-stage advance enables from the top level to the lanes
  typedef struct packed {
    logic s1_en;
    logic s2_en;
  } yta_stage_en_t;

  // scaled components from one lane, before the final shift
  typedef struct packed {
    logic [SCL_W-1:0] r;
    logic [SCL_W-1:0] g;
    logic [SCL_W-1:0] b;
  } yta_lane_out_t;

  // drop fraction, clamp to 0..255; negative sums give 0
  function automatic logic [7:0] clamp_comp(input logic signed [SUM_W-1:0] sum);
    logic [SUM_W-1:0] shifted;
    shifted = SUM_W'($unsigned(sum) >> COEF_FRAC_BITS);
    if (sum[SUM_W-1]) begin
      clamp_comp = 8'd0;
    end else if (shifted > SUM_W'(COMP_MAX)) begin
      clamp_comp = COMP_MAX;
    end else begin
      clamp_comp = shifted[7:0];
    end
  endfunction

  // divide by 256 and saturate
  function automatic logic [7:0] sat_scaled(input logic [SCL_W-1:0] scl);
    logic [SCL_W-9:0] hi;
    hi = scl[SCL_W-1:8];
    if (hi > (SCL_W-8)'(COMP_MAX)) begin
      sat_scaled = COMP_MAX;
    end else begin
      sat_scaled = hi[7:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/yta_lane.sv
// ----------------------------------------------------------------------------
// yta_lane
// one pixel lane: chroma products, sums, clamp and gain multiply
// ----------------------------------------------------------------------------
`default_nettype none

module yta_lane (
  input  wire logic                                clk_i,
  input  wire yta_pkg::yta_stage_en_t              en_i,
  input  wire logic [7:0]                          luma_i,
  input  wire logic signed [yta_pkg::DELTA_W-1:0]  du_i,
  input  wire logic signed [yta_pkg::DELTA_W-1:0]  dv_i,
  input  wire logic [yta_pkg::GAIN_W-1:0]          gain_i,
  output yta_pkg::yta_lane_out_t                   lane_o
);

  localparam int PW = yta_pkg::PROD_W;
  localparam int SW = yta_pkg::SUM_W;
  localparam int FB = yta_pkg::COEF_FRAC_BITS;

  // stage 1: coefficient products
  logic [7:0]           y_q;
  logic signed [PW-1:0] prv_q, pgv_q, pgu_q, pbu_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1_en) begin
      y_q   <= luma_i;
      prv_q <= PW'(yta_pkg::COEF_RV * dv_i);
      pgv_q <= PW'(yta_pkg::COEF_GV * dv_i);
      pgu_q <= PW'(yta_pkg::COEF_GU * du_i);
      pbu_q <= PW'(yta_pkg::COEF_BU * du_i);
    end
  end

  // stage 2: sums, clamp, gain
  logic signed [SW-1:0] base, sum_r, sum_g, sum_b;
  logic [7:0]           c_r, c_g, c_b;
  yta_pkg::yta_lane_out_t scl_d, scl_q;

  always_comb begin
    base  = $signed({{(SW-8-FB){1'b0}}, y_q, {FB{1'b0}}});
    sum_r = base + SW'(prv_q);
    sum_g = base - SW'(pgv_q) - SW'(pgu_q);
    sum_b = base + SW'(pbu_q);
    c_r   = yta_pkg::clamp_comp(sum_r);
    c_g   = yta_pkg::clamp_comp(sum_g);
    c_b   = yta_pkg::clamp_comp(sum_b);
    scl_d.r = yta_pkg::SCL_W'(c_r) * yta_pkg::SCL_W'(gain_i);
    scl_d.g = yta_pkg::SCL_W'(c_g) * yta_pkg::SCL_W'(gain_i);
    scl_d.b = yta_pkg::SCL_W'(c_b) * yta_pkg::SCL_W'(gain_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2_en) begin
      scl_q <= scl_d;
    end
  end

  assign lane_o = scl_q;

endmodule

`default_nettype wire

FILE: rtl/yuyv_to_argb_converter.sv
// ----------------------------------------------------------------------------
// yuyv_to_argb_converter
// yuyv 4:2:2 word to two argb32 pixels with output gain
// ----------------------------------------------------------------------------
// Each accepted word (Y0, U, Y1, V plus frame-end mark) gives one output word
// holding two ARGB pixels that share the chroma. The block takes one word per
// clock cycle unless a blocked output has filled every stage. Each result
// passes one register stage for the coefficient products, one for sum, clamp
// and gain multiply, and the output register where the gain result is divided
// by 256, saturated and packed. Two identical lanes work on the two pixels side
// by side and the output stage merges them. Empty stages close up, so words are
// still accepted while a result waits at the output, until all three stages
// are full. output_gain is written through cfg_we_i/cfg_wdata_i and resets to
// 220; write it only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "yuyv_to_argb_converter_assert.svh"

module yuyv_to_argb_converter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire yta_pkg::yta_in_t                  in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output yta_pkg::yta_out_t                      out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [yta_pkg::GAIN_W-1:0]        cfg_wdata_i
);

  localparam int DW = yta_pkg::DELTA_W;

  // gain register
  logic [yta_pkg::GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= yta_pkg::GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  // stage valids; a stage advances when it is empty or the next one moves
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  yta_pkg::yta_stage_en_t stage_en;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stage_en.s1_en = en1;
  assign stage_en.s2_en = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;

  // shared chroma, offset removed
  logic signed [DW-1:0] du, dv;

  assign du = $signed({1'b0, in_data_i.chroma_blue}) - $signed(yta_pkg::CHROMA_OFFSET);
  assign dv = $signed({1'b0, in_data_i.chroma_red}) - $signed(yta_pkg::CHROMA_OFFSET);

  // frame-end mark rides alongside the lanes
  logic last1_q, last2_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      last1_q <= in_data_i.last_in_frame;
    end
    if (en2) begin
      last2_q <= last1_q;
    end
  end

  // two pixel lanes
  yta_pkg::yta_lane_out_t lane0, lane1;

  yta_lane u_lane0 (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .luma_i (in_data_i.luma_first),
    .du_i   (du),
    .dv_i   (dv),
    .gain_i (gain_q),
    .lane_o (lane0)
  );

  yta_lane u_lane1 (
    .clk_i  (clk_i),
    .en_i   (stage_en),
    .luma_i (in_data_i.luma_second),
    .du_i   (du),
    .dv_i   (dv),
    .gain_i (gain_q),
    .lane_o (lane1)
  );

  // merge: divide by 256, saturate, pack alpha r g b
  yta_pkg::yta_out_t out_d, out_q;

  always_comb begin
    out_d.first_pixel_argb  = {yta_pkg::ALPHA_BYTE,
                               yta_pkg::sat_scaled(lane0.r),
                               yta_pkg::sat_scaled(lane0.g),
                               yta_pkg::sat_scaled(lane0.b)};
    out_d.second_pixel_argb = {yta_pkg::ALPHA_BYTE,
                               yta_pkg::sat_scaled(lane1.r),
                               yta_pkg::sat_scaled(lane1.g),
                               yta_pkg::sat_scaled(lane1.b)};
    out_d.frame_end         = last2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // input only stalls when every stage is full and the output is blocked
  `YTA_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !in_ready_o,
                  v1_q && v2_q && v3_q && !out_ready_i)
  // an accepted word lands in the first stage
  `YTA_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_valid_i && in_ready_o, v1_q)
  // a blocked result is held in place
  `YTA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, v3_q && !out_ready_i,
                   v3_q && $stable(out_q))
  // both pixels carry an opaque alpha
  `YTA_ASSERT_NOW(a_alpha, clk_i, rst_ni, out_valid_o,
                  out_q.first_pixel_argb[31:24] == yta_pkg::ALPHA_BYTE &&
                  out_q.second_pixel_argb[31:24] == yta_pkg::ALPHA_BYTE)

endmodule

`default_nettype wire
